// ----- rtl/core/ibw_pkg.sv -----
// shared types and constants of the top-level box walker
package ibw_pkg;

  // inspection window limit and derived widths
  localparam int PROBE_BYTES = 1048576;
  localparam int OFF_W       = $clog2(PROBE_BYTES) + 1;
  localparam int CNT_W       = 18;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // header layout
  localparam int HDR_W          = 4;
  localparam logic [HDR_W-1:0] HDR_FIRST     = 4'd0;
  localparam logic [HDR_W-1:0] HDR_SIZE_LAST = 4'd3;
  localparam logic [HDR_W-1:0] HDR_EXT_FIRST = 4'd8;
  localparam logic [HDR_W-1:0] HDR_EXT_LAST  = 4'd15;
  localparam int MIN_HDR_BYTES  = 8;
  localparam int MIN_EXT_BYTES  = 16;
  localparam int SIZE_TO_END    = 0;
  localparam int SIZE_EXTENDED  = 1;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int PREFIX_W   = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 8'd1;

  // result kinds
  localparam logic KIND_BOX     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CONF_NONE,
    CONF_WEAK,
    CONF_PROBABLE,
    CONF_STRONG
  } ibw_conf_t;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_BODY,
    ST_DONE
  } ibw_state_t;

  typedef struct packed {
    logic [OFF_W-1:0] w;
    logic             fully;
    logic [OFF_W-1:0] src_low;
  } ibw_win_t;

  typedef struct packed {
    logic             ev;
    logic             sm;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] length;
    logic [OFF_W-1:0] decl;
    logic             to_end;
    logic [CNT_W-1:0] count;
    ibw_conf_t        conf;
    logic [OFF_W-1:0] inspected;
    logic             fully;
  } ibw_rec_t;

  function automatic ibw_conf_t conf_of(input logic [CNT_W-1:0] cnt);
    ibw_conf_t c;
    if (cnt >= CNT_W'(3)) c = CONF_STRONG;
    else                  c = ibw_conf_t'(cnt[1:0]);
    return c;
  endfunction

endpackage

// ----- rtl/core/ibw_window.sv -----
// configuration registers and inspection window
module ibw_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ibw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ibw_pkg::CFG_DATA_W-1:0]      cfg_data,
  output ibw_pkg::ibw_win_t                   win
);

  logic [ibw_pkg::CFG_DATA_W-1:0] src_r, src_nxt;
  logic [ibw_pkg::PREFIX_W-1:0]   pre_r, pre_nxt;
  logic [ibw_pkg::OFF_W-1:0]      w_r, w_nxt;
  logic                           fully_r, fully_nxt;
  logic                           src_big, pre_big;
  logic [ibw_pkg::OFF_W-1:0]      src_clip, pre_clip;
  logic                           wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_comb begin
    src_nxt = src_r;
    pre_nxt = pre_r;
    if (wr && cfg_index == ibw_pkg::CFG_SOURCE_SIZE)   src_nxt = cfg_data;
    if (wr && cfg_index == ibw_pkg::CFG_PREFIX_LENGTH) pre_nxt = cfg_data[ibw_pkg::PREFIX_W-1:0];
    // clip both to the probe limit, then take the lesser
    src_big  = src_nxt > ibw_pkg::CFG_DATA_W'(ibw_pkg::PROBE_BYTES);
    pre_big  = pre_nxt > ibw_pkg::PREFIX_W'(ibw_pkg::PROBE_BYTES);
    src_clip = src_big ? ibw_pkg::OFF_W'(ibw_pkg::PROBE_BYTES) : src_nxt[ibw_pkg::OFF_W-1:0];
    pre_clip = pre_big ? ibw_pkg::OFF_W'(ibw_pkg::PROBE_BYTES) : pre_nxt[ibw_pkg::OFF_W-1:0];
    w_nxt    = (src_clip < pre_clip) ? src_clip : pre_clip;
    fully_nxt = !src_big &&
                (src_nxt <= {{(ibw_pkg::CFG_DATA_W-ibw_pkg::PREFIX_W){1'b0}}, pre_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r   <= '0;
      pre_r   <= ibw_pkg::PREFIX_W'(1);
      w_r     <= '0;
      fully_r <= 1'b1;
    end else begin
      src_r   <= src_nxt;
      pre_r   <= pre_nxt;
      w_r     <= w_nxt;
      fully_r <= fully_nxt;
    end
  end

  assign win.w       = w_r;
  assign win.fully   = fully_r;
  assign win.src_low = src_r[ibw_pkg::OFF_W-1:0];

endmodule

// ----- rtl/core/ibw_front.sv -----
// box header walker: classifies each byte and builds result records
module ibw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_take,
  input  logic [7:0]           data_byte,
  input  ibw_pkg::ibw_win_t    win,
  output logic                 push,
  output ibw_pkg::ibw_rec_t    rec
);

  localparam int OW = ibw_pkg::OFF_W;

  ibw_pkg::ibw_state_t            st_r, st_nxt;
  logic [ibw_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  logic [31:0]                    short_r, short_nxt, short_new;
  logic [63:0]                    long_r, long_nxt, long_new;
  logic [OW-1:0]                  start_r, start_nxt;
  logic [OW-1:0]                  pos_r, pos_nxt;
  logic [OW-1:0]                  end_r, end_nxt;
  logic [ibw_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [OW-1:0]                  rem;
  logic                           ev, sm, to_end;
  logic [OW-1:0]                  len, decl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ibw_pkg::ST_HEADER;
      hdr_r   <= '0;
      short_r <= '0;
      long_r  <= '0;
      start_r <= '0;
      pos_r   <= '0;
      end_r   <= '0;
      cnt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      hdr_r   <= hdr_nxt;
      short_r <= short_nxt;
      long_r  <= long_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    rem       = (win.w > start_r) ? (win.w - start_r) : '0;
    short_new = {short_r[23:0], data_byte};
    long_new  = {long_r[55:0], data_byte};
    st_nxt    = st_r;
    hdr_nxt   = hdr_r;
    short_nxt = short_r;
    long_nxt  = long_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    end_nxt   = end_r;
    ev        = 1'b0;
    sm        = 1'b0;
    to_end    = 1'b0;
    len       = '0;
    decl      = '0;
    if (byte_take) begin
      unique case (st_r)
        ibw_pkg::ST_HEADER: begin
          hdr_nxt = hdr_r + 1'b1;
          pos_nxt = pos_r + 1'b1;
          if (hdr_r <= ibw_pkg::HDR_SIZE_LAST) short_nxt = short_new;
          if (hdr_r >= ibw_pkg::HDR_EXT_FIRST) long_nxt = long_new;
          if (hdr_r == ibw_pkg::HDR_FIRST && rem < OW'(ibw_pkg::MIN_HDR_BYTES)) begin
            sm = 1'b1;
          end else if (hdr_r == ibw_pkg::HDR_SIZE_LAST) begin
            if (short_new == 32'(ibw_pkg::SIZE_TO_END)) begin
              // to-end box only counts when the whole source is in view
              if (win.fully) begin
                ev     = 1'b1;
                to_end = 1'b1;
                len    = win.src_low - start_r;
              end
              sm = 1'b1;
            end else if (short_new == 32'(ibw_pkg::SIZE_EXTENDED)) begin
              if (rem < OW'(ibw_pkg::MIN_EXT_BYTES)) sm = 1'b1;
            end else if (short_new < 32'(ibw_pkg::MIN_HDR_BYTES)) begin
              sm = 1'b1;
            end else if (short_new > 32'(rem)) begin
              sm = 1'b1;
            end else begin
              ev      = 1'b1;
              len     = short_new[OW-1:0];
              decl    = short_new[OW-1:0];
              st_nxt  = ibw_pkg::ST_BODY;
              end_nxt = start_r + short_new[OW-1:0];
            end
          end else if (hdr_r == ibw_pkg::HDR_EXT_LAST) begin
            if (long_new < 64'(ibw_pkg::MIN_EXT_BYTES) || long_new > 64'(rem)) begin
              sm = 1'b1;
            end else begin
              ev   = 1'b1;
              len  = long_new[OW-1:0];
              decl = long_new[OW-1:0];
              if (long_new == 64'(ibw_pkg::MIN_EXT_BYTES)) begin
                // header-only box closes on its last header byte
                start_nxt = start_r + OW'(ibw_pkg::MIN_EXT_BYTES);
                hdr_nxt   = '0;
                short_nxt = '0;
                long_nxt  = '0;
                if ({1'b0, win.w} < ({1'b0, start_r} +
                    (OW+1)'(ibw_pkg::MIN_EXT_BYTES + ibw_pkg::MIN_HDR_BYTES))) begin
                  sm = 1'b1;
                end
              end else begin
                st_nxt  = ibw_pkg::ST_BODY;
                end_nxt = start_r + long_new[OW-1:0];
              end
            end
          end
        end
        ibw_pkg::ST_BODY: begin
          pos_nxt = pos_r + 1'b1;
          if ({1'b0, pos_r} + (OW+1)'(1) == {1'b0, end_r}) begin
            start_nxt = end_r;
            hdr_nxt   = '0;
            short_nxt = '0;
            long_nxt  = '0;
            st_nxt    = ibw_pkg::ST_HEADER;
            if ({1'b0, win.w} < ({1'b0, end_r} + (OW+1)'(ibw_pkg::MIN_HDR_BYTES))) sm = 1'b1;
          end
        end
        ibw_pkg::ST_DONE: begin
          // trailing bytes are dropped
        end
        default: begin
          st_nxt = ibw_pkg::ST_DONE;
        end
      endcase
      if (sm) st_nxt = ibw_pkg::ST_DONE;
    end
    cnt_nxt = (ev && cnt_r != ibw_pkg::CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

    push          = ev | sm;
    rec.ev        = ev;
    rec.sm        = sm;
    rec.offset    = start_r;
    rec.length    = len;
    rec.decl      = decl;
    rec.to_end    = to_end;
    rec.count     = cnt_nxt;
    rec.conf      = ibw_pkg::conf_of(cnt_nxt);
    rec.inspected = win.w;
    rec.fully     = win.fully;
  end

endmodule

// ----- rtl/core/ibw_queue.sv -----
// short record queue between walker and result emitter
module ibw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ibw_pkg::ibw_rec_t  push_rec,
  input  logic               pop,
  output ibw_pkg::ibw_rec_t  head,
  output logic               not_empty,
  output logic               full
);

  ibw_pkg::ibw_rec_t                 mem_r [ibw_pkg::QUEUE_DEPTH];
  logic [ibw_pkg::QPTR_W-1:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ibw_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  function automatic logic [ibw_pkg::QPTR_W-1:0] bump(input logic [ibw_pkg::QPTR_W-1:0] p);
    logic [ibw_pkg::QPTR_W-1:0] n;
    if (p == ibw_pkg::QPTR_W'(ibw_pkg::QUEUE_DEPTH - 1)) n = '0;
    else                                                 n = p + 1'b1;
    return n;
  endfunction

  always_comb begin
    wp_nxt  = push ? bump(wp_r) : wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_rec;
  end

  assign head      = mem_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == ibw_pkg::QCNT_W'(ibw_pkg::QUEUE_DEPTH);

endmodule

// ----- rtl/core/ibw_back.sv -----
// result emitter: one or two beats per queued record
module ibw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ibw_pkg::ibw_rec_t             head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [ibw_pkg::OFF_W-1:0]     out_box_offset,
  output logic [ibw_pkg::OFF_W-1:0]     out_box_length,
  output logic [ibw_pkg::OFF_W-1:0]     out_declared_size,
  output logic                          out_runs_to_end,
  output logic [1:0]                    out_confidence,
  output logic [ibw_pkg::CNT_W-1:0]     out_box_count,
  output logic [ibw_pkg::OFF_W-1:0]     out_inspected_bytes,
  output logic                          out_fully_inspected,
  output logic                          out_last
);

  logic part_r, part_nxt;   // evidence beat of the head record already sent
  logic show_box, take;

  assign show_box = head.ev && !part_r;
  assign take     = head_valid && out_ready;
  assign pop      = take && (!show_box || !head.sm);

  always_comb begin
    part_nxt = part_r;
    if (pop)       part_nxt = 1'b0;
    else if (take) part_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) part_r <= 1'b0;
    else        part_r <= part_nxt;
  end

  always_comb begin
    out_valid           = head_valid;
    out_box_count       = head.count;
    out_inspected_bytes = head.inspected;
    out_fully_inspected = head.fully;
    if (show_box) begin
      out_kind          = ibw_pkg::KIND_BOX;
      out_box_offset    = head.offset;
      out_box_length    = head.length;
      out_declared_size = head.decl;
      out_runs_to_end   = head.to_end;
      out_confidence    = ibw_pkg::CONF_NONE;
      out_last          = 1'b0;
    end else begin
      out_kind          = ibw_pkg::KIND_SUMMARY;
      out_box_offset    = '0;
      out_box_length    = '0;
      out_declared_size = '0;
      out_runs_to_end   = 1'b0;
      out_confidence    = head.conf;
      out_last          = 1'b1;
    end
  end

endmodule

// ----- rtl/core/iso_box_header_walker.sv -----
// top level of the iso media top-level box walker
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    in_data_byte: one source byte per beat
//  out      out  out_valid / out_ready  box evidence or final summary per beat
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data: one register write per beat
//
// one byte per cycle unless stalled; each byte is classified in the cycle it is taken
// a byte gives at most one queued record, which leaves as one or two output beats
// in_ready drops only while the four-entry record queue is full; cfg_ready is always high
// synchronous active-low reset clears the walk, source_size to 0, prefix_length to 1
// after the summary beat further bytes are taken and dropped until reset
module iso_box_header_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [ibw_pkg::OFF_W-1:0]     out_box_offset,
  output logic [ibw_pkg::OFF_W-1:0]     out_box_length,
  output logic [ibw_pkg::OFF_W-1:0]     out_declared_size,
  output logic                          out_runs_to_end,
  output logic [1:0]                    out_confidence,
  output logic [ibw_pkg::CNT_W-1:0]     out_box_count,
  output logic [ibw_pkg::OFF_W-1:0]     out_inspected_bytes,
  output logic                          out_fully_inspected,
  output logic                          out_last,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ibw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ibw_pkg::CFG_DATA_W-1:0] cfg_data
);

  ibw_pkg::ibw_win_t win;        // window size and full-coverage flag
  ibw_pkg::ibw_rec_t rec;        // record built from the current byte
  ibw_pkg::ibw_rec_t head;       // oldest queued record
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_valid;
  logic              byte_take;

  // a byte beat is taken whenever the queue has room for its record
  assign in_ready  = !q_full;
  assign byte_take = in_valid & in_ready;

  // configuration registers; window recomputed at each write
  ibw_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  // header walk and box bookkeeping
  ibw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .win       (win),
    .push      (push),
    .rec       (rec)
  );

  // decouples the walker from output back-pressure
  ibw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (rec),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // splits each record into evidence and summary beats
  ibw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .head_valid          (q_valid),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_box_offset      (out_box_offset),
    .out_box_length      (out_box_length),
    .out_declared_size   (out_declared_size),
    .out_runs_to_end     (out_runs_to_end),
    .out_confidence      (out_confidence),
    .out_box_count       (out_box_count),
    .out_inspected_bytes (out_inspected_bytes),
    .out_fully_inspected (out_fully_inspected),
    .out_last            (out_last)
  );

endmodule
